// ===== hw/rtl/acs_pkg.sv =====
package acs_pkg;

  // default knot slots per channel
  localparam int MAX_KNOTS_DEF = 16;

  // field widths
  localparam int CNT_W = 5;
  localparam int X_W   = 16;
  localparam int Y_W   = 17;
  localparam int YS_W  = 18;
  localparam int CFG_IW = 2;

  // datapath word
  localparam int DW = 64;
  typedef logic signed [DW-1:0] word_t;

  // saturation limits
  localparam word_t SLOPE_LIM = 64'sh0000_0000_4000_0000;
  localparam word_t PROD_LIM  = 64'sh1000_0000_0000_0000;

  // divider passes: short for chords and two-knot interpolation, long for wide numerators
  localparam int DIV_SHORT = 34;
  localparam int DIV_LONG  = 64;
  localparam int DCNT_W    = 7;

  // operation codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  // channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_NONE  = 2'd3;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_RED_COUNT   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_GREEN_COUNT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_BLUE_COUNT  = 2'd2;

endpackage

// ===== hw/rtl/akima_curve_sampler_top.sv =====
// Akima curve sampler: a knot write does not raise busy; an evaluation item runs through
// one shared 32x32 multiplier (low half then high half of the wide operand) and one
// radix-2 divider (short or long pass per quotient), run in turn.
// One item at a time; next item accepted the cycle the result strobe is shown.
// The receiver cannot stall: out_valid is high for exactly one cycle per evaluation.
// Sync active-low reset clears sequencer and counts; knot tables undefined until written.
module akima_curve_sampler_top #(
  parameter int MAX_KNOTS = acs_pkg::MAX_KNOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [1:0]                  in_channel,
  input  logic [3:0]                  in_knot_index,
  input  logic [acs_pkg::X_W-1:0]     in_knot_x,
  input  logic signed [acs_pkg::Y_W-1:0] in_knot_y,
  input  logic [acs_pkg::X_W-1:0]     in_query_pos,
  // result strobe
  output logic                        out_valid,
  output logic [1:0]                  out_channel,
  output logic [15:0]                 out_sample_value,
  output logic [7:0]                  out_lut_byte,
  output logic                        out_degenerate,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [acs_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [acs_pkg::CNT_W-1:0]   cfg_data
);

  localparam int NW    = $clog2(MAX_KNOTS + 1);
  localparam int DEPTH = 3 * MAX_KNOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW    = acs_pkg::X_W + acs_pkg::YS_W;

  typedef enum logic [26:0] {
    ST_IDLE    = 27'h0000001,
    ST_S1RD    = 27'h0000002,
    ST_S1CMP   = 27'h0000004,
    ST_S2RD    = 27'h0000008,
    ST_S2CMP   = 27'h0000010,
    ST_SBIN    = 27'h0000020,
    ST_SBCMP   = 27'h0000040,
    ST_LOAD    = 27'h0000080,
    ST_DISP    = 27'h0000100,
    ST_TWO_D   = 27'h0000200,
    ST_TWO_F   = 27'h0000400,
    ST_CHORD   = 27'h0000800,
    ST_CHORD_W = 27'h0001000,
    ST_EXT1    = 27'h0002000,
    ST_EXT2    = 27'h0004000,
    ST_TAN0    = 27'h0008000,
    ST_TAN1    = 27'h0010000,
    ST_TAN2    = 27'h0020000,
    ST_TAN3    = 27'h0040000,
    ST_PD      = 27'h0080000,
    ST_PV      = 27'h0100000,
    ST_TERM    = 27'h0200000,
    ST_MUL0    = 27'h0400000,
    ST_MUL1    = 27'h0800000,
    ST_DIV     = 27'h1000000,
    ST_OUT     = 27'h2000000,
    ST_SPARE   = 27'h4000000
  } state_t;

  // ---------------------------------------------------------------- helpers
  function automatic logic [63:0] mag64(input acs_pkg::word_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic acs_pkg::word_t clamp_slope(input acs_pkg::word_t v);
    if (v > acs_pkg::SLOPE_LIM) return acs_pkg::SLOPE_LIM;
    if (v < -acs_pkg::SLOPE_LIM) return -acs_pkg::SLOPE_LIM;
    return v;
  endfunction

  // 2a-b, clamped as a slope
  function automatic acs_pkg::word_t ext_slope(input acs_pkg::word_t a, input acs_pkg::word_t b);
    return clamp_slope((a <<< 1) - b);
  endfunction

  // divide by 65536, truncating toward zero
  function automatic acs_pkg::word_t tr16(input acs_pkg::word_t v);
    logic [63:0] m;
    m = mag64(v) >> 16;
    return v[63] ? -acs_pkg::word_t'(m) : acs_pkg::word_t'(m);
  endfunction

  function automatic acs_pkg::word_t ux(input logic [acs_pkg::X_W-1:0] x);
    return acs_pkg::word_t'({48'd0, x});
  endfunction

  // ---------------------------------------------------------------- storage
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [NW-1:0] rd_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_knot_x, {in_knot_y[acs_pkg::Y_W-1], in_knot_y}};
    end
    rd_q <= mem[rd_addr];
  end

  logic [acs_pkg::X_W-1:0] rd_x;
  assign rd_x = rd_q[MW-1 -: acs_pkg::X_W];

  // ---------------------------------------------------------------- registers
  state_t st_r, st_nxt, ret_r, ret_nxt;
  logic [acs_pkg::CNT_W-1:0] red_cnt_r, green_cnt_r, blue_cnt_r;
  logic [1:0]    ch_r, ch_nxt;
  logic [acs_pkg::X_W-1:0] t_r, t_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [NW-1:0] n_r, n_nxt, kk_r, kk_nxt, ks_r, ks_nxt, m_r, m_nxt, l_r, l_nxt;
  logic [2:0]    j_r, j_nxt, k_r, k_nxt;
  logic          tsel_r, tsel_nxt, term_r, term_nxt, deg_r, deg_nxt;
  logic [acs_pkg::X_W-1:0] wx_r [6];
  logic [acs_pkg::X_W-1:0] wx_nxt [6];
  logic signed [acs_pkg::YS_W-1:0] wy_r [6];
  logic signed [acs_pkg::YS_W-1:0] wy_nxt [6];
  acs_pkg::word_t u_r [5];
  acs_pkg::word_t u_nxt [5];
  acs_pkg::word_t p_r, p_nxt, q_r, q_nxt, v_r, v_nxt, res_r, res_nxt, pr1_r, pr1_nxt;
  // shared multiply/divide unit
  logic [63:0]   ma_r, ma_nxt, plo_r, plo_nxt, dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [31:0]   mb_r, mb_nxt;
  logic [33:0]   dsr_r, dsr_nxt, rem_r, rem_nxt;
  logic [acs_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic          neg_r, neg_nxt, sat_r, sat_nxt;
  // result
  logic          out_valid_r, out_valid_nxt, out_deg_r, out_deg_nxt;
  logic [1:0]    out_ch_r, out_ch_nxt;
  logic [15:0]   out_sv_r, out_sv_nxt;
  logic [7:0]    out_lut_r, out_lut_nxt;

  // ---------------------------------------------------------------- datapath taps
  logic [4:0] ex;                      // chord at window place j exists
  always_comb begin
    for (int j = 0; j < 5; j++) begin
      ex[j] = (int'(kk_r) + j - 2 >= 0) && (int'(kk_r) + j - 2 <= int'(n_r) - 2);
    end
  end

  acs_pkg::word_t ua, ub, wa, wb, ssum, d_w, h_w, a_w, b_w;
  logic [63:0]    sa, sb;
  always_comb begin
    ua = tsel_r ? u_r[2] : u_r[1];
    ub = tsel_r ? u_r[3] : u_r[2];
    wa = tsel_r ? (u_r[3] - u_r[4]) : (u_r[3] - u_r[2]);
    wb = tsel_r ? (u_r[2] - u_r[1]) : (u_r[0] - u_r[1]);
    sa = mag64(wa);
    sb = mag64(wb);
    ssum = ua + ub;
    d_w = ux(t_r) - ux(wx_r[2]);
    h_w = ux(wx_r[3]) - ux(wx_r[2]);
    a_w = (u_r[2] <<< 1) + u_r[2] - (p_r <<< 1) - q_r;
    b_w = q_r + p_r - (u_r[2] <<< 1);
  end

  // one 32x32 product, low half then high half of the wide operand
  logic [31:0] mul_a;
  logic [63:0] pp;
  logic [95:0] pfull;
  logic [63:0] pmag;
  assign mul_a = (st_r == ST_MUL0) ? ma_r[31:0] : ma_r[63:32];
  assign pp    = 64'(mul_a) * 64'(mb_r);
  assign pfull = 96'(plo_r) + {pp, 32'd0};
  assign pmag  = (sat_r && pfull > 96'(acs_pkg::PROD_LIM)) ? 64'(acs_pkg::PROD_LIM)
                                                           : pfull[63:0];

  // one restoring divider step
  logic [34:0] dsh, ddif;
  logic        dbit;
  logic [63:0] quo_step;
  assign dsh      = {rem_r, dvd_r[63]};
  assign ddif     = dsh - {1'b0, dsr_r};
  assign dbit     = (dsh >= {1'b0, dsr_r});
  assign quo_step = {quo_r[62:0], dbit};

  // call requests to the shared unit
  logic           mul_req, div_req, op_sat, op_long;
  acs_pkg::word_t opx, opy;
  state_t         op_ret;

  logic [NW-1:0] n_in;
  logic [acs_pkg::CNT_W-1:0] cnt_in;
  int            widx;
  logic [63:0]   dmag, ymag;
  acs_pkg::word_t vcl;
  logic [23:0]   lut_p;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    st_nxt = st_r;      ret_nxt = ret_r;
    ch_nxt = ch_r;      t_nxt = t_r;        base_nxt = base_r;
    n_nxt = n_r;        kk_nxt = kk_r;      ks_nxt = ks_r;    m_nxt = m_r;  l_nxt = l_r;
    j_nxt = j_r;        k_nxt = k_r;        tsel_nxt = tsel_r; term_nxt = term_r;
    deg_nxt = deg_r;
    wx_nxt = wx_r;      wy_nxt = wy_r;      u_nxt = u_r;
    p_nxt = p_r;        q_nxt = q_r;        v_nxt = v_r;      res_nxt = res_r;
    pr1_nxt = pr1_r;
    ma_nxt = ma_r;      mb_nxt = mb_r;      plo_nxt = plo_r;  dvd_nxt = dvd_r;
    quo_nxt = quo_r;    dsr_nxt = dsr_r;    rem_nxt = rem_r;  dcnt_nxt = dcnt_r;
    neg_nxt = neg_r;    sat_nxt = sat_r;
    out_valid_nxt = 1'b0;
    out_ch_nxt = out_ch_r; out_sv_nxt = out_sv_r; out_lut_nxt = out_lut_r;
    out_deg_nxt = out_deg_r;
    mul_req = 1'b0;     div_req = 1'b0;     op_sat = 1'b0;    op_long = 1'b0;
    opx = '0;           opy = '0;           op_ret = ST_IDLE;
    wr_en = 1'b0;
    rd_idx = '0;
    widx = 0;
    vcl = '0;
    lut_p = '0;
    wr_addr = AW'(int'(in_channel) * MAX_KNOTS + int'(in_knot_index));
    unique case (in_channel)
      acs_pkg::CH_RED:   cnt_in = red_cnt_r;
      acs_pkg::CH_GREEN: cnt_in = green_cnt_r;
      default:           cnt_in = blue_cnt_r;
    endcase
    n_in = (int'(cnt_in) > MAX_KNOTS) ? NW'(MAX_KNOTS) : NW'(cnt_in);

    unique case (st_r)
      ST_IDLE: begin
        if (start && in_channel != acs_pkg::CH_NONE) begin
          if (in_func == acs_pkg::FUNC_WRITE) begin
            wr_en = (int'(in_knot_index) < MAX_KNOTS);
          end else begin
            ch_nxt   = in_channel;
            t_nxt    = in_query_pos;
            base_nxt = AW'(int'(in_channel) * MAX_KNOTS);
            n_nxt    = n_in;
            deg_nxt  = 1'b0;
            v_nxt    = '0;
            kk_nxt   = '0;
            j_nxt    = '0;
            if (n_in == '0)               st_nxt = ST_OUT;
            else if (int'(n_in) <= 2)     st_nxt = ST_LOAD;
            else                          st_nxt = ST_S1RD;
          end
        end
      end
      // interval search
      ST_S1RD: begin
        rd_idx = NW'(1);
        st_nxt = ST_S1CMP;
      end
      ST_S1CMP: begin
        if (t_r <= rd_x) begin
          kk_nxt = '0;
          j_nxt  = '0;
          st_nxt = ST_LOAD;
        end else begin
          st_nxt = ST_S2RD;
        end
      end
      ST_S2RD: begin
        rd_idx = n_r - NW'(1);
        st_nxt = ST_S2CMP;
      end
      ST_S2CMP: begin
        if (t_r >= rd_x) begin
          kk_nxt = n_r - NW'(2);
          j_nxt  = '0;
          st_nxt = ST_LOAD;
        end else begin
          ks_nxt = NW'(1);
          m_nxt  = n_r;
          st_nxt = ST_SBIN;
        end
      end
      ST_SBIN: begin
        l_nxt  = NW'((int'(ks_r) + int'(m_r)) >> 1);
        rd_idx = l_nxt - NW'(1);
        if (int'(m_r) - int'(ks_r) == 1) begin
          kk_nxt = ks_r - NW'(1);
          j_nxt  = '0;
          st_nxt = ST_LOAD;
        end else begin
          st_nxt = ST_SBCMP;
        end
      end
      ST_SBCMP: begin
        if (t_r < rd_x) m_nxt = l_r;
        else            ks_nxt = l_r;
        st_nxt = ST_SBIN;
      end
      // window of six knots around the interval, one read a cycle
      ST_LOAD: begin
        widx = int'(kk_r) + int'(j_r) - 2;
        if (widx >= 0 && widx < int'(n_r)) rd_idx = NW'(widx);
        if (j_r != 3'd0) begin
          wx_nxt[j_r - 3'd1] = rd_x;
          wy_nxt[j_r - 3'd1] = rd_q[acs_pkg::YS_W-1:0];
        end
        j_nxt = j_r + 3'd1;
        if (j_r == 3'd6) st_nxt = ST_DISP;
      end
      ST_DISP: begin
        if (n_r == NW'(1)) begin
          v_nxt  = acs_pkg::word_t'(wy_r[2]);
          st_nxt = ST_OUT;
        end else if (int'(n_r) == 2) begin
          if (h_w == '0) begin
            deg_nxt = 1'b1;
            v_nxt   = acs_pkg::word_t'(wy_r[2]);
            st_nxt  = ST_OUT;
          end else begin
            mul_req = 1'b1;
            opx     = acs_pkg::word_t'(wy_r[3]) - acs_pkg::word_t'(wy_r[2]);
            opy     = d_w;
            op_ret  = ST_TWO_D;
          end
        end else begin
          j_nxt  = '0;
          st_nxt = ST_CHORD;
        end
      end
      ST_TWO_D: begin
        div_req = 1'b1;
        opx     = res_r;
        opy     = h_w;
        op_ret  = ST_TWO_F;
      end
      ST_TWO_F: begin
        v_nxt  = acs_pkg::word_t'(wy_r[2]) + res_r;
        st_nxt = ST_OUT;
      end
      // chord slopes of the window, zero-width ones flagged
      ST_CHORD: begin
        if (j_r == 3'd5) begin
          st_nxt = ST_EXT1;
        end else if (ex[j_r]) begin
          if (wx_r[j_r + 3'd1] == wx_r[j_r]) begin
            u_nxt[j_r] = '0;
            deg_nxt    = 1'b1;
            j_nxt      = j_r + 3'd1;
          end else begin
            div_req = 1'b1;
            opx     = (acs_pkg::word_t'(wy_r[j_r + 3'd1]) -
                       acs_pkg::word_t'(wy_r[j_r])) <<< 16;
            opy     = ux(wx_r[j_r + 3'd1]) - ux(wx_r[j_r]);
            op_ret  = ST_CHORD_W;
          end
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      ST_CHORD_W: begin
        u_nxt[j_r] = clamp_slope(res_r);
        j_nxt      = j_r + 3'd1;
        st_nxt     = ST_CHORD;
      end
      // slopes past the curve ends
      ST_EXT1: begin
        if (!ex[1]) u_nxt[1] = ext_slope(u_r[2], u_r[3]);
        if (!ex[3]) u_nxt[3] = ext_slope(u_r[2], u_r[1]);
        st_nxt = ST_EXT2;
      end
      ST_EXT2: begin
        if (!ex[0]) u_nxt[0] = ext_slope(u_r[1], u_r[2]);
        if (!ex[4]) u_nxt[4] = ext_slope(u_r[3], u_r[2]);
        tsel_nxt = 1'b0;
        st_nxt   = ST_TAN0;
      end
      // end tangents: weighted mean, or plain mean when both weights vanish
      ST_TAN0: begin
        if (sa == '0 && sb == '0) begin
          if (tsel_r) q_nxt = (ssum + acs_pkg::word_t'(ssum[63])) >>> 1;
          else        p_nxt = (ssum + acs_pkg::word_t'(ssum[63])) >>> 1;
          tsel_nxt = 1'b1;
          st_nxt   = tsel_r ? ST_PD : ST_TAN0;
        end else begin
          mul_req = 1'b1;
          opx     = ua;
          opy     = acs_pkg::word_t'(sa);
          op_ret  = ST_TAN1;
        end
      end
      ST_TAN1: begin
        pr1_nxt = res_r;
        mul_req = 1'b1;
        opx     = ub;
        opy     = acs_pkg::word_t'(sb);
        op_ret  = ST_TAN2;
      end
      ST_TAN2: begin
        div_req = 1'b1;
        op_long = 1'b1;
        opx     = pr1_r + res_r;
        opy     = acs_pkg::word_t'(sa + sb);
        op_ret  = ST_TAN3;
      end
      ST_TAN3: begin
        if (tsel_r) q_nxt = res_r;
        else        p_nxt = res_r;
        tsel_nxt = 1'b1;
        st_nxt   = tsel_r ? ST_PD : ST_TAN0;
      end
      // linear term
      ST_PD: begin
        mul_req = 1'b1;
        opx     = p_r;
        opy     = d_w;
        op_ret  = ST_PV;
      end
      ST_PV: begin
        v_nxt = acs_pkg::word_t'(wy_r[2]) + tr16(res_r);
        if (h_w == '0) begin
          deg_nxt = 1'b1;
          st_nxt  = ST_OUT;
        end else begin
          term_nxt = 1'b0;
          k_nxt    = '0;
          st_nxt   = ST_TERM;
        end
      end
      // quadratic then cubic term: multiply by d, divide by h, alternately
      ST_TERM: begin
        if (k_r == (term_r ? 3'd5 : 3'd3)) begin
          v_nxt    = v_r + tr16(res_r);
          term_nxt = 1'b1;
          k_nxt    = '0;
          if (term_r) st_nxt = ST_OUT;
        end else begin
          opx    = (k_r == 3'd0) ? (term_r ? b_w : a_w) : res_r;
          op_ret = ST_TERM;
          k_nxt  = k_r + 3'd1;
          if (!k_r[0]) begin
            mul_req = 1'b1;
            op_sat  = 1'b1;
            opy     = d_w;
          end else begin
            div_req = 1'b1;
            op_long = 1'b1;
            opy     = h_w;
          end
        end
      end
      // shared unit
      ST_MUL0: begin
        plo_nxt = pp;
        st_nxt  = ST_MUL1;
      end
      ST_MUL1: begin
        res_nxt = neg_r ? -acs_pkg::word_t'(pmag) : acs_pkg::word_t'(pmag);
        st_nxt  = ret_r;
      end
      ST_DIV: begin
        if (dbit) rem_nxt = ddif[33:0];
        else      rem_nxt = dsh[33:0];
        dvd_nxt  = {dvd_r[62:0], 1'b0};
        quo_nxt  = quo_step;
        dcnt_nxt = dcnt_r - acs_pkg::DCNT_W'(1);
        if (dcnt_r == acs_pkg::DCNT_W'(1)) begin
          res_nxt = neg_r ? -acs_pkg::word_t'(quo_step) : acs_pkg::word_t'(quo_step);
          st_nxt  = ret_r;
        end
      end
      ST_OUT: begin
        if (v_r[63])                          vcl = '0;
        else if (v_r > 64'sd32768)            vcl = 64'sd32768;
        else                                  vcl = v_r;
        lut_p         = {vcl[15:0], 8'd0} - 24'(vcl[15:0]);
        out_sv_nxt    = vcl[15:0];
        out_lut_nxt   = lut_p[22:15];
        out_ch_nxt    = ch_r;
        out_deg_nxt   = deg_r;
        out_valid_nxt = 1'b1;
        st_nxt        = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    dmag = mag64(opx);
    ymag = mag64(opy);
    if (mul_req) begin
      ma_nxt  = dmag;
      mb_nxt  = ymag[31:0];
      neg_nxt = opx[63] ^ opy[63];
      sat_nxt = op_sat;
      ret_nxt = op_ret;
      st_nxt  = ST_MUL0;
    end
    if (div_req) begin
      dvd_nxt  = op_long ? dmag : (dmag << (acs_pkg::DIV_LONG - acs_pkg::DIV_SHORT));
      dsr_nxt  = ymag[33:0];
      rem_nxt  = '0;
      quo_nxt  = '0;
      dcnt_nxt = op_long ? acs_pkg::DCNT_W'(acs_pkg::DIV_LONG)
                         : acs_pkg::DCNT_W'(acs_pkg::DIV_SHORT);
      neg_nxt  = opx[63] ^ opy[63];
      ret_nxt  = op_ret;
      st_nxt   = ST_DIV;
    end
  end

  assign rd_addr = AW'(int'(base_r) + int'(rd_idx));

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
      red_cnt_r   <= '0;
      green_cnt_r <= '0;
      blue_cnt_r  <= '0;
    end else begin
      st_r        <= st_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        if (cfg_index == acs_pkg::REG_RED_COUNT)   red_cnt_r   <= cfg_data;
        if (cfg_index == acs_pkg::REG_GREEN_COUNT) green_cnt_r <= cfg_data;
        if (cfg_index == acs_pkg::REG_BLUE_COUNT)  blue_cnt_r  <= cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;     t_r <= t_nxt;       base_r <= base_nxt;
    n_r <= n_nxt;       kk_r <= kk_nxt;     ks_r <= ks_nxt;   m_r <= m_nxt;  l_r <= l_nxt;
    j_r <= j_nxt;       k_r <= k_nxt;       tsel_r <= tsel_nxt; term_r <= term_nxt;
    deg_r <= deg_nxt;
    wx_r <= wx_nxt;     wy_r <= wy_nxt;     u_r <= u_nxt;
    p_r <= p_nxt;       q_r <= q_nxt;       v_r <= v_nxt;     res_r <= res_nxt;
    pr1_r <= pr1_nxt;
    ma_r <= ma_nxt;     mb_r <= mb_nxt;     plo_r <= plo_nxt; dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;   dsr_r <= dsr_nxt;   rem_r <= rem_nxt; dcnt_r <= dcnt_nxt;
    neg_r <= neg_nxt;   sat_r <= sat_nxt;
    out_ch_r <= out_ch_nxt; out_sv_r <= out_sv_nxt; out_lut_r <= out_lut_nxt;
    out_deg_r <= out_deg_nxt;
  end

  assign busy             = (st_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_channel      = out_ch_r;
  assign out_sample_value = out_sv_r;
  assign out_lut_byte     = out_lut_r;
  assign out_degenerate   = out_deg_r;

endmodule
